### sv/sle_pkg.sv
// sle_pkg: request kinds, status codes and field widths of the sequential list engine
// no dependencies; used by sequential_list_engine by scoped names
`default_nettype none

package sle_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned PosW   = 11;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LenW   = 11;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  typedef logic [KindW-1:0] kind_t;
  typedef logic [StatW-1:0] status_t;

  localparam kind_t REQ_INSERT = 2'd0;
  localparam kind_t REQ_DELETE = 2'd1;
  localparam kind_t REQ_GET    = 2'd2;
  localparam kind_t REQ_CLEAR  = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

### sv/sequential_list_engine.sv
// sequential_list_engine: ordered list of 32-bit words with positional insert, delete, get, clear
// depends on sle_pkg; holds the element memory and its shift sequencer
//
//   channel  dir  tdata (low bit up)                        tuser
//   s_axis   in   position[10:0], value[42:11], zero fill   req_type[1:0]
//   m_axis   out  read_value[31:0], list_length[42:32]      status[1:0]
//
// one request at a time; the memory port moves one element per cycle
// insert: S_INS moves elements up one slot, S_INS_W writes the value; an append skips S_INS
// delete: S_DEL_CAP reads, S_DEL and S_DEL_W move later ones down; a last element skips both
// get: S_GET_CAP; clear, errors: S_RESP only; S_RESP holds while a result waits on m_axis
// reset empties the list at once; memory contents need no clearing
// the next request is taken while a finished result waits on m_axis
`default_nettype none

module sequential_list_engine #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // position[10:0], value[42:11]
  input  wire logic [sle_pkg::InDataW-1:0]    s_axis_tdata,
  // req_type[1:0]
  input  wire logic [sle_pkg::KindW-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // read_value[31:0], list_length[42:32]
  output logic [sle_pkg::OutDataW-1:0]        m_axis_tdata,
  // status[1:0]
  output logic [sle_pkg::StatW-1:0]           m_axis_tuser
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned PW  = ((CW > sle_pkg::PosW) ? CW : sle_pkg::PosW) + 1;
  localparam int unsigned VW  = sle_pkg::ValW;
  localparam int unsigned LW  = sle_pkg::LenW;
  localparam int unsigned PadW = sle_pkg::OutDataW - VW - LW;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS     = 3'd1;
  localparam logic [2:0] S_INS_W   = 3'd2;
  localparam logic [2:0] S_DEL_CAP = 3'd3;
  localparam logic [2:0] S_DEL     = 3'd4;
  localparam logic [2:0] S_DEL_W   = 3'd5;
  localparam logic [2:0] S_GET_CAP = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] stop_q, stop_d;
  logic [VW-1:0] val_q, val_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;

  sle_pkg::status_t res_status_q, res_status_d;
  logic [VW-1:0]    res_value_q, res_value_d;

  logic             out_valid_q;
  sle_pkg::status_t out_status_q;
  logic [VW-1:0]    out_value_q;
  logic [LW-1:0]    out_len_q;
  logic             out_load;

  logic [VW-1:0] mem_q [DEPTH];
  logic [VW-1:0] rdata_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  logic                 req_acc;
  sle_pkg::kind_t       in_kind;
  logic [sle_pkg::PosW-1:0] in_pos;
  logic [VW-1:0]        in_val;
  logic [PW-1:0]        pos_ext, cnt_ext, pos_m1;
  logic                 bad_ins, bad_rd, is_full;

  assign s_axis_tready = (state_q == S_IDLE);
  assign req_acc       = s_axis_tvalid && s_axis_tready;
  assign in_kind       = s_axis_tuser;
  assign in_pos        = s_axis_tdata[sle_pkg::PosW-1:0];
  assign in_val        = s_axis_tdata[sle_pkg::PosW+VW-1:sle_pkg::PosW];

  assign pos_ext = PW'(in_pos);
  assign cnt_ext = PW'(count_q);
  assign pos_m1  = pos_ext - PW'(1);
  assign bad_ins = (in_pos == '0) || (pos_ext > (cnt_ext + PW'(1)));
  assign bad_rd  = (in_pos == '0) || (pos_ext > cnt_ext);
  assign is_full = (count_q == CW'(DEPTH));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    stop_d       = stop_q;
    val_d        = val_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    rd_en        = 1'b0;
    rd_addr      = ptr_q[AW-1:0];
    wr_en        = pend_q;
    wr_addr      = pend_addr_q;
    wr_data      = rdata_q;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          res_status_d = sle_pkg::ST_OK;
          res_value_d  = '0;
          state_d      = S_RESP;
          case (in_kind)
            sle_pkg::REQ_INSERT: begin
              if (bad_ins) begin
                res_status_d = sle_pkg::ST_RANGE;
              end else if (is_full) begin
                res_status_d = sle_pkg::ST_FULL;
              end else begin
                val_d  = in_val;
                stop_d = CW'(pos_m1);
                if (pos_m1 == cnt_ext) begin
                  state_d = S_INS_W;
                end else begin
                  ptr_d   = count_q - CW'(1);
                  state_d = S_INS;
                end
              end
            end
            sle_pkg::REQ_DELETE: begin
              if (bad_rd) begin
                res_status_d = sle_pkg::ST_RANGE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = AW'(pos_m1);
                ptr_d   = CW'(pos_ext);
                stop_d  = count_q - CW'(1);
                state_d = S_DEL_CAP;
              end
            end
            sle_pkg::REQ_GET: begin
              if (bad_rd) begin
                res_status_d = sle_pkg::ST_RANGE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = AW'(pos_m1);
                state_d = S_GET_CAP;
              end
            end
            default: begin
              count_d = '0;
            end
          endcase
        end
      end
      S_INS: begin
        rd_en       = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = AW'(ptr_q + CW'(1));
        if (ptr_q == stop_q) begin
          state_d = S_INS_W;
        end else begin
          ptr_d = ptr_q - CW'(1);
        end
      end
      S_INS_W: begin
        if (!pend_q) begin
          wr_en   = 1'b1;
          wr_addr = stop_q[AW-1:0];
          wr_data = val_q;
          count_d = count_q + CW'(1);
          state_d = S_RESP;
        end
      end
      S_DEL_CAP: begin
        res_value_d = rdata_q;
        if (ptr_q == count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_RESP;
        end else begin
          state_d = S_DEL;
        end
      end
      S_DEL: begin
        rd_en       = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = AW'(ptr_q - CW'(1));
        if (ptr_q == stop_q) begin
          state_d = S_DEL_W;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      S_DEL_W: begin
        count_d = count_q - CW'(1);
        state_d = S_RESP;
      end
      S_GET_CAP: begin
        res_value_d = rdata_q;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    stop_q       <= stop_d;
    val_q        <= val_d;
    pend_addr_q  <= pend_addr_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_len_q    <= LW'(count_q);
    end
  end

  // element memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {PadW'(0), out_len_q, out_value_q};

`ifndef SYNTH
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !s_axis_tready)
    else $error("request taken while a request is in work");

  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("element move still pending at idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> (count_q <= CW'(DEPTH)))
    else $error("list length beyond depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (res_status_q != sle_pkg::ST_OK) |=> (m_axis_tdata[VW-1:0] == '0))
    else $error("error result carries a value");
`endif

endmodule

`default_nettype wire

### dv/sequential_list_engine_tb.sv
// sequential_list_engine_tb: self-checking bench for the positional list engine
// a queue-fed driver and a monitor with random stalls, checked against a shadow list
// depends on sle_pkg and sequential_list_engine
module sequential_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ListDepth   = 1024;
  localparam int RandomItems = 557;
  localparam int IdleLimit   = 10000;
  localparam int DrainCycles = 64;
  localparam int MaxGap      = 13;

  typedef struct packed {
    sle_pkg::kind_t           kind;
    logic [sle_pkg::PosW-1:0] pos;
    logic [sle_pkg::ValW-1:0] val;
    logic                     drain;
  } request_t;

  typedef struct packed {
    sle_pkg::status_t         status;
    logic [sle_pkg::ValW-1:0] rd;
    logic [sle_pkg::LenW-1:0] len;
  } response_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // position[10:0], value[42:11]
  logic [sle_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  // req_type[1:0]
  logic [sle_pkg::KindW-1:0]    s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // read_value[31:0], list_length[42:32]
  logic [sle_pkg::OutDataW-1:0] m_axis_tdata;
  // status[1:0]
  logic [sle_pkg::StatW-1:0]    m_axis_tuser;

  request_t                 request_q [$];
  response_t                response_q [$];
  logic [sle_pkg::ValW-1:0] list_shadow [$];

  int plan_len    = 0;
  int target_len  = 0;
  int sent_cnt    = 0;
  int recv_cnt    = 0;
  int err_cnt     = 0;
  int idle_cycles = 0;
  int tx_wait     = 0;
  int tx_left     = 0;
  bit tx_calm     = 1'b0;
  bit tx_fire     = 1'b0;
  int rx_wait     = 0;
  int rx_left     = 0;
  bit rx_calm     = 1'b0;

  sequential_list_engine #(
    .DEPTH(ListDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int draw_gap(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(10, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic logic [sle_pkg::ValW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic response_t apply_request(request_t r);
    response_t rsp;
    int p;
    int n;
    p = r.pos;
    n = list_shadow.size();
    rsp.status = sle_pkg::ST_OK;
    rsp.rd = '0;
    case (r.kind)
      sle_pkg::REQ_INSERT: begin
        if (p < 1 || p > n + 1) rsp.status = sle_pkg::ST_RANGE;
        else if (n >= ListDepth) rsp.status = sle_pkg::ST_FULL;
        else list_shadow.insert(p - 1, r.val);
      end
      sle_pkg::REQ_DELETE: begin
        if (p < 1 || p > n) begin
          rsp.status = sle_pkg::ST_RANGE;
        end else begin
          rsp.rd = list_shadow[p - 1];
          list_shadow.delete(p - 1);
        end
      end
      sle_pkg::REQ_GET: begin
        if (p < 1 || p > n) rsp.status = sle_pkg::ST_RANGE;
        else rsp.rd = list_shadow[p - 1];
      end
      default: list_shadow.delete();
    endcase
    n = list_shadow.size();
    rsp.len = n[sle_pkg::LenW-1:0];
    return rsp;
  endfunction

  task automatic add_req(sle_pkg::kind_t k, int p, logic [sle_pkg::ValW-1:0] v, logic drain);
    request_t r;
    r.kind  = k;
    r.pos   = p[sle_pkg::PosW-1:0];
    r.val   = v;
    r.drain = drain;
    request_q.push_back(r);
    case (k)
      sle_pkg::REQ_INSERT:
        if (p >= 1 && p <= plan_len + 1 && plan_len < ListDepth) plan_len++;
      sle_pkg::REQ_DELETE: if (p >= 1 && p <= plan_len) plan_len--;
      sle_pkg::REQ_CLEAR:  plan_len = 0;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t ns: %s", $time, what);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait = draw_gap(tx_left, tx_calm);
    end else begin
      tx_fire = s_axis_tvalid && s_axis_tready;
      if (tx_fire) begin
        response_q.push_back(apply_request(request_q[0]));
        request_q.pop_front();
        sent_cnt <= sent_cnt + 1;
        tx_wait = draw_gap(tx_left, tx_calm);
      end
      if (s_axis_tvalid && !tx_fire) begin
      end else if (tx_wait > 0) begin
        tx_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() != 0 &&
                   (!request_q[0].drain || (!tx_fire && sent_cnt == recv_cnt))) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(sle_pkg::InDataW - sle_pkg::PosW - sle_pkg::ValW){1'b0}},
                          request_q[0].val, request_q[0].pos};
        s_axis_tuser  <= request_q[0].kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    response_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait = draw_gap(rx_left, rx_calm);
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (response_q.size() == 0) begin
          report_mismatch($sformatf("unrequested response status %0d value %h length %0d",
                                    m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[42:32]));
        end else begin
          want = response_q.pop_front();
          if (m_axis_tuser !== want.status || m_axis_tdata[31:0] !== want.rd ||
              m_axis_tdata[42:32] !== want.len)
            report_mismatch($sformatf(
              "response %0d got status %0d value %h length %0d, want %0d %h %0d",
              recv_cnt, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[42:32],
              want.status, want.rd, want.len));
        end
        recv_cnt <= recv_cnt + 1;
        rx_wait = draw_gap(rx_left, rx_calm);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL sequential_list_engine");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    int sel;
    int pos;
    sle_pkg::kind_t kind;

    // empty list, bad positions, front/middle/end inserts, gets, deletes, clear
    add_req(sle_pkg::REQ_GET, 1, '0, 1'b0);
    add_req(sle_pkg::REQ_DELETE, 1, '1, 1'b0);
    add_req(sle_pkg::REQ_INSERT, 0, 32'h1, 1'b0);
    add_req(sle_pkg::REQ_INSERT, 2, 32'h2, 1'b0);
    add_req(sle_pkg::REQ_INSERT, 1, 32'h7fff_ffff, 1'b0);
    add_req(sle_pkg::REQ_INSERT, 1, 32'h8000_0000, 1'b0);
    add_req(sle_pkg::REQ_INSERT, 3, '0, 1'b0);
    add_req(sle_pkg::REQ_INSERT, 2, '1, 1'b0);
    for (i = 0; i <= 5; i++) add_req(sle_pkg::REQ_GET, i, $urandom, 1'b0);
    add_req(sle_pkg::REQ_DELETE, 2, '0, 1'b0);
    add_req(sle_pkg::REQ_DELETE, 0, '0, 1'b0);
    add_req(sle_pkg::REQ_DELETE, 3, '0, 1'b0);
    add_req(sle_pkg::REQ_GET, 2047, '0, 1'b0);
    add_req(sle_pkg::REQ_INSERT, 1025, '0, 1'b0);
    add_req(sle_pkg::REQ_CLEAR, 2047, '1, 1'b1);
    add_req(sle_pkg::REQ_GET, 1, '0, 1'b0);
    add_req(sle_pkg::REQ_INSERT, 1, 32'h5555_5555, 1'b0);
    add_req(sle_pkg::REQ_DELETE, 1, '0, 1'b0);

    for (i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0)
        target_len = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 40);

      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        kind = sle_pkg::kind_t'($urandom_range(0, 2));
        pos = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(plan_len + 2, 2047);
      end else if (sel < 10) begin
        kind = sle_pkg::kind_t'($urandom_range(0, 3));
        pos = $urandom_range(0, 2047);
      end else if (sel < 13) begin
        kind = sle_pkg::REQ_CLEAR;
        pos = $urandom_range(0, 2047);
      end else begin
        if (plan_len == 0 || $urandom_range(0, 99) < ((plan_len < target_len) ? 65 : 30))
          kind = sle_pkg::REQ_INSERT;
        else
          kind = ($urandom_range(0, 1) == 0) ? sle_pkg::REQ_DELETE : sle_pkg::REQ_GET;
        if (kind == sle_pkg::REQ_INSERT) pos = $urandom_range(1, plan_len + 1);
        else pos = $urandom_range(1, plan_len);
      end
      add_req(kind, pos, pick_value(), ($urandom_range(0, 49) == 0));
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || sent_cnt != recv_cnt) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (response_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", response_q.size()));

    if (err_cnt == 0) begin
      $display("PASS sequential_list_engine");
    end else begin
      $display("FAIL sequential_list_engine");
    end
    $finish;
  end

endmodule

### files.f
sv/sle_pkg.sv
sv/sequential_list_engine.sv
dv/sequential_list_engine_tb.sv
